// File: rtl/mpp_pkg.sv
// ----------------------------------------------------------------------------
// mpp_pkg
// Shared types and constants for the motor profile PI controller: transaction
// payloads, register map, mode codes and the serial arithmetic unit commands.
// ----------------------------------------------------------------------------
package mpp_pkg;

  // Input transaction
  typedef struct packed {
    logic [1:0]         mode;
    logic signed [31:0] encoder_count;
    logic [23:0]        elapsed_us;
    logic signed [31:0] target_value;
    logic               forward_request;
    logic               restart_move;
  } mpp_in_t;

  // Result transaction
  typedef struct packed {
    logic [7:0]         pwm_duty;
    logic               drive_forward;
    logic               arrived;
    logic signed [31:0] position_mm_q8;
    logic signed [31:0] speed_estimate_q8;
  } mpp_out_t;

  // Control modes
  localparam logic [1:0] MODE_SPEED = 2'd0;
  localparam logic [1:0] MODE_ABS   = 2'd1;
  localparam logic [1:0] MODE_REL   = 2'd2;
  localparam logic [1:0] MODE_HOLD  = 2'd3; // no control action, drive held

  // Register indexes (byte address = 4 * index)
  localparam logic [1:0] REG_SPEED_LIMIT = 2'd0;
  localparam logic [1:0] REG_ARRIVE_THR  = 2'd1;
  localparam logic [1:0] REG_ACCEL_RATE  = 2'd2;

  localparam logic [23:0] SPEED_LIMIT_RST = 24'd51200;
  localparam logic [23:0] ARRIVE_THR_RST  = 24'd256;
  localparam logic [23:0] ACCEL_RATE_RST  = 24'd25600;

  // Fixed-point constants
  localparam logic [23:0] POS_SCALE_Q16 = 24'd5819711; // 256*120*pi/(98.8*11), Q16
  localparam logic [23:0] US_PER_S      = 24'd1000000;
  localparam logic [23:0] HALF_US_PER_S = 24'd500000;
  localparam logic [16:0] PWM_MAX_Q8    = 17'd65280;

  // Serial arithmetic unit
  localparam int ALU_AW = 60;
  localparam int ALU_BW = 24;
  localparam int ALU_CW = 6;

  typedef enum logic [1:0] {
    OP_MUL  = 2'd0,
    OP_DIV  = 2'd1,
    OP_SQRT = 2'd2
  } mpp_op_t;

  typedef struct packed {
    logic               start;
    mpp_op_t            op;
    logic [ALU_AW-1:0]  a;
    logic [ALU_BW-1:0]  b;
  } mpp_alu_cmd_t;

  typedef struct packed {
    logic busy;
    logic done;
  } mpp_alu_sts_t;

endpackage

// File: rtl/mpp_ram.sv
// ----------------------------------------------------------------------------
// mpp_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module mpp_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 8
) (
  input  logic                                    clk,
  input  logic                                    we,
  input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] waddr,
  input  logic [WIDTH-1:0]                        wdata,
  input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] raddr,
  output logic [WIDTH-1:0]                        rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: rtl/mpp_arith.sv
// ----------------------------------------------------------------------------
// mpp_arith
// Shared bit-serial arithmetic unit: shift-add multiply (one multiplier bit
// per cycle), restoring divide (one quotient bit per cycle) and square root
// (one root bit per cycle).
// ----------------------------------------------------------------------------
module mpp_arith (
  input  logic                      clk,
  input  logic                      rst_n,
  input  mpp_pkg::mpp_alu_cmd_t     cmd,
  output mpp_pkg::mpp_alu_sts_t     sts,
  output logic [mpp_pkg::ALU_AW-1:0] result
);
  import mpp_pkg::*;

  mpp_op_t           op_r, op_nxt;
  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [ALU_CW-1:0] cnt_r, cnt_nxt;
  logic [ALU_AW-1:0] a_r, a_nxt;
  logic [ALU_BW-1:0] b_r, b_nxt;
  logic [ALU_AW-1:0] acc_r, acc_nxt;
  logic [31:0]       rem_r, rem_nxt;

  logic [24:0] div_t;
  logic        div_ge;
  logic [33:0] sq_t;
  logic [33:0] sq_trial;
  logic        sq_ge;

  // Divide and square-root step terms
  assign div_t    = {rem_r[23:0], a_r[ALU_AW-1]};
  assign div_ge   = div_t >= {1'b0, b_r};
  assign sq_t     = {rem_r, a_r[ALU_AW-1:ALU_AW-2]};
  assign sq_trial = {2'b00, acc_r[29:0], 2'b01};
  assign sq_ge    = sq_t >= sq_trial;

  always_comb begin
    op_nxt   = op_r;
    busy_nxt = busy_r;
    cnt_nxt  = cnt_r;
    a_nxt    = a_r;
    b_nxt    = b_r;
    acc_nxt  = acc_r;
    rem_nxt  = rem_r;
    done_nxt = 1'b0;
    if (cmd.start) begin
      op_nxt   = cmd.op;
      busy_nxt = 1'b1;
      a_nxt    = cmd.a;
      b_nxt    = cmd.b;
      acc_nxt  = '0;
      rem_nxt  = '0;
      case (cmd.op)
        OP_MUL:  cnt_nxt = ALU_CW'(ALU_BW - 1);
        OP_DIV:  cnt_nxt = ALU_CW'(ALU_AW - 1);
        OP_SQRT: cnt_nxt = ALU_CW'(ALU_AW / 2 - 1);
        default: cnt_nxt = '0;
      endcase
    end else if (busy_r) begin
      case (op_r)
        OP_MUL: begin
          if (b_r[0]) begin
            acc_nxt = acc_r + a_r;
          end
          a_nxt = a_r << 1;
          b_nxt = b_r >> 1;
        end
        OP_DIV: begin
          rem_nxt = div_ge ? 32'(div_t - {1'b0, b_r}) : 32'(div_t);
          acc_nxt = {acc_r[ALU_AW-2:0], div_ge};
          a_nxt   = a_r << 1;
        end
        OP_SQRT: begin
          rem_nxt = sq_ge ? 32'(sq_t - sq_trial) : sq_t[31:0];
          acc_nxt = {acc_r[ALU_AW-2:0], sq_ge};
          a_nxt   = a_r << 2;
        end
        default: begin
          acc_nxt = acc_r;
        end
      endcase
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end else begin
        cnt_nxt = cnt_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      op_r   <= OP_MUL;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      op_r   <= op_nxt;
      cnt_r  <= cnt_nxt;
    end
    a_r   <= a_nxt;
    b_r   <= b_nxt;
    acc_r <= acc_nxt;
    rem_r <= rem_nxt;
  end

  assign sts.busy = busy_r;
  assign sts.done = done_r;
  assign result   = acc_r;

endmodule

// File: rtl/motor_profile_pi_controller.sv
// Arithmetic: one shared bit-serial unit does every multiply, divide and root.
// Throughput: one transaction at a time; the next is taken in the cycle after the
//   result is handed to the output register, which may still be waiting.
// Reset (synchronous, rst_n low): registers to defaults, history, PI state cleared.
// ----------------------------------------------------------------------------
// motor_profile_pi_controller
// Encoder-to-position conversion, moving-average speed, trapezoidal profile
// with square-root braking and PI speed loop, all in Q.8 fixed point.
// ----------------------------------------------------------------------------
module motor_profile_pi_controller #(
  parameter int AVG_DEPTH = 8
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  mpp_pkg::mpp_in_t  in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output mpp_pkg::mpp_out_t out_data,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [3:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);
  import mpp_pkg::*;

  localparam int SLOT_W = $clog2(AVG_DEPTH > 1 ? AVG_DEPTH : 2);
  localparam int SUM_W  = 32 + SLOT_W;

  typedef enum logic [14:0] {
    S_IDLE  = 15'b000000000000001,
    S_POS   = 15'b000000000000010,
    S_SMUL  = 15'b000000000000100,
    S_SDIV  = 15'b000000000001000,
    S_WIN   = 15'b000000000010000,
    S_EST   = 15'b000000000100000,
    S_BMUL  = 15'b000000001000000,
    S_VMUL  = 15'b000000010000000,
    S_SQRT  = 15'b000000100000000,
    S_RMUL  = 15'b000001000000000,
    S_RDIV  = 15'b000010000000000,
    S_PIMUL = 15'b000100000000000,
    S_PIDIV = 15'b001000000000000,
    S_PPDIV = 15'b010000000000000,
    S_DONE  = 15'b100000000000000
  } state_t;

  function automatic logic [31:0] sat32(input logic neg, input logic [ALU_AW-1:0] mag);
    if (neg) begin
      return (mag > 60'h80000000) ? 32'h80000000 : (~mag[31:0] + 32'd1);
    end
    return (mag > 60'h7FFFFFFF) ? 32'h7FFFFFFF : mag[31:0];
  endfunction

  state_t                   state_r, state_nxt;
  logic                     launched_r, launched_nxt;
  mpp_in_t                  item_r, item_nxt;
  logic [23:0]              spd_lim_r, thr_r, accel_r;
  logic signed [31:0]       pos_r, pos_nxt;
  logic signed [31:0]       prev_pos_r, prev_pos_nxt;
  logic signed [31:0]       sample_r, sample_nxt;
  logic signed [SUM_W-1:0]  sum_r, sum_nxt;
  logic [SLOT_W-1:0]        slot_r, slot_nxt;
  logic [AVG_DEPTH-1:0]     wvalid_r, wvalid_nxt;
  logic signed [31:0]       est_r, est_nxt;
  logic [ALU_AW-1:0]        work_r, work_nxt;
  logic signed [34:0]       left_r, left_nxt;
  logic [23:0]              v_r, v_nxt;
  logic signed [33:0]       tgt_r, tgt_nxt;
  logic signed [39:0]       integ_r, integ_nxt;
  logic signed [31:0]       base_r, base_nxt;
  logic signed [31:0]       pdelta_r, pdelta_nxt;
  logic [7:0]               duty_r, duty_nxt;
  logic                     fwd_r, fwd_nxt;
  logic                     arr_r, arr_nxt;
  logic                     out_valid_r, out_valid_nxt;
  mpp_out_t                 out_r, out_nxt;

  mpp_alu_cmd_t      cmd;
  mpp_alu_sts_t      sts;
  logic [ALU_AW-1:0] res;

  logic                     ram_we;
  logic [31:0]              ram_rdata;

  // Datapath helper terms
  logic [31:0]        cnt_mag;
  logic [ALU_AW-1:0]  pos_q;
  logic signed [32:0] diff;
  logic [32:0]        diff_mag;
  logic signed [31:0] old_sample;
  logic [SUM_W-1:0]   sum_mag;
  logic [23:0]        dt_pi;
  logic [23:0]        dt_prof;
  logic signed [31:0] base_eff;
  logic signed [33:0] goal;
  logic signed [34:0] left_now;
  logic [34:0]        dist_now;
  logic [34:0]        dist_r;
  logic signed [33:0] spd_tgt;
  logic signed [34:0] err;
  logic [34:0]        err_mag;
  logic [41:0]        q42;
  logic signed [41:0] isum;
  logic signed [39:0] integ_sat;
  logic [42:0]        q43;
  logic signed [42:0] pi_sum;
  logic [42:0]        pi_mag;
  logic [16:0]        pi_clamp;
  logic [16:0]        duty_sum;
  logic [29:0]        root_v;
  logic [30:0]        ramp_v;
  logic [23:0]        v_clamp_sqrt;
  logic [23:0]        v_clamp_ramp;

  mpp_arith u_arith (
    .clk    (clk),
    .rst_n  (rst_n),
    .cmd    (cmd),
    .sts    (sts),
    .result (res)
  );

  mpp_ram #(
    .WIDTH (32),
    .DEPTH (AVG_DEPTH)
  ) u_window (
    .clk   (clk),
    .we    (ram_we),
    .waddr (slot_r),
    .wdata (sample_r),
    .raddr (slot_r),
    .rdata (ram_rdata)
  );

  // Position and speed sample terms
  assign cnt_mag  = item_r.encoder_count[31] ? (~item_r.encoder_count + 32'd1)
                                             : item_r.encoder_count;
  assign pos_q    = (res + 60'd32768) >> 16;
  assign diff     = {pos_r[31], pos_r} - {prev_pos_r[31], prev_pos_r};
  assign diff_mag = diff[32] ? (~diff + 33'd1) : diff;

  // Window old entry reads as zero until written since reset
  assign old_sample = wvalid_r[slot_r] ? ram_rdata : 32'sd0;
  assign sum_mag    = sum_r[SUM_W-1] ? (~sum_r + 1'b1) : sum_r;

  // Time steps
  assign dt_pi   = (item_r.elapsed_us > US_PER_S) ? 24'd0 : item_r.elapsed_us;
  assign dt_prof = item_r.restart_move ? 24'd0 : item_r.elapsed_us;

  // Profile goal and remaining distance
  assign base_eff = (item_r.target_value != pdelta_r) ? pos_r : base_r;
  assign goal     = (item_r.mode == MODE_REL)
                    ? ({{2{item_r.target_value[31]}}, item_r.target_value}
                       + {{2{base_eff[31]}}, base_eff})
                    : {{2{item_r.target_value[31]}}, item_r.target_value};
  assign left_now = {goal[33], goal} - {{3{pos_r[31]}}, pos_r};
  assign dist_now = left_now[34] ? (~left_now + 35'd1) : left_now;
  assign dist_r   = left_r[34] ? (~left_r + 35'd1) : left_r;
  assign spd_tgt  = item_r.forward_request
                    ? {{2{item_r.target_value[31]}}, item_r.target_value}
                    : -{{2{item_r.target_value[31]}}, item_r.target_value};

  // Profile speed update
  assign root_v       = res[29:0];
  assign v_clamp_sqrt = (root_v > {6'd0, spd_lim_r}) ? spd_lim_r : root_v[23:0];
  assign ramp_v       = {7'd0, v_r} + {1'b0, res[29:0]};
  assign v_clamp_ramp = (ramp_v > {7'd0, spd_lim_r}) ? spd_lim_r : ramp_v[23:0];

  // PI terms
  assign err     = {tgt_r[33], tgt_r} - {{3{est_r[31]}}, est_r};
  assign err_mag = err[34] ? (~err + 35'd1) : err;
  assign q42     = err[34] ? (~res[41:0] + 42'd1) : res[41:0];
  assign isum    = {{2{integ_r[39]}}, integ_r} + q42;
  assign integ_sat = (isum[41:39] == 3'b000 || isum[41:39] == 3'b111) ? isum[39:0]
                   : (isum[41] ? 40'sh8000000000 : 40'sh7FFFFFFFFF);
  assign q43     = err[34] ? (~res[42:0] + 43'd1) : res[42:0];
  assign pi_sum  = q43 + {{3{integ_r[39]}}, integ_r};
  assign pi_mag  = pi_sum[42] ? (~pi_sum + 43'd1) : pi_sum;
  assign pi_clamp = (pi_mag > {26'd0, PWM_MAX_Q8}) ? PWM_MAX_Q8 : pi_mag[16:0];
  assign duty_sum = pi_clamp + 17'd128;

  // Sequencer
  always_comb begin
    state_nxt     = state_r;
    launched_nxt  = launched_r;
    item_nxt      = item_r;
    pos_nxt       = pos_r;
    prev_pos_nxt  = prev_pos_r;
    sample_nxt    = sample_r;
    sum_nxt       = sum_r;
    slot_nxt      = slot_r;
    wvalid_nxt    = wvalid_r;
    est_nxt       = est_r;
    work_nxt      = work_r;
    left_nxt      = left_r;
    v_nxt         = v_r;
    tgt_nxt       = tgt_r;
    integ_nxt     = integ_r;
    base_nxt      = base_r;
    pdelta_nxt    = pdelta_r;
    duty_nxt      = duty_r;
    fwd_nxt       = fwd_r;
    arr_nxt       = arr_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_nxt       = out_r;
    ram_we        = 1'b0;
    cmd.start     = 1'b0;
    cmd.op        = OP_MUL;
    cmd.a         = '0;
    cmd.b         = '0;

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          item_nxt  = in_data;
          arr_nxt   = 1'b0;
          state_nxt = S_POS;
        end
      end

      // Position: count times scale, rounded from Q16
      S_POS: begin
        cmd.start    = !launched_r;
        cmd.op       = OP_MUL;
        cmd.a        = ALU_AW'(cnt_mag);
        cmd.b        = POS_SCALE_Q16;
        launched_nxt = 1'b1;
        if (sts.done) begin
          launched_nxt = 1'b0;
          pos_nxt      = sat32(item_r.encoder_count[31], pos_q);
          state_nxt    = S_SMUL;
        end
      end

      // Speed sample numerator: position change times 1e6, plus rounding
      S_SMUL: begin
        if (item_r.elapsed_us == '0) begin
          sample_nxt = '0;
          state_nxt  = S_WIN;
        end else begin
          cmd.start    = !launched_r;
          cmd.op       = OP_MUL;
          cmd.a        = ALU_AW'(diff_mag);
          cmd.b        = US_PER_S;
          launched_nxt = 1'b1;
          if (sts.done) begin
            launched_nxt = 1'b0;
            work_nxt     = res + ALU_AW'(item_r.elapsed_us >> 1);
            state_nxt    = S_SDIV;
          end
        end
      end

      S_SDIV: begin
        cmd.start    = !launched_r;
        cmd.op       = OP_DIV;
        cmd.a        = work_r;
        cmd.b        = item_r.elapsed_us;
        launched_nxt = 1'b1;
        if (sts.done) begin
          launched_nxt = 1'b0;
          sample_nxt   = sat32(diff[32], res);
          state_nxt    = S_WIN;
        end
      end

      // Window update: replace the oldest sample
      S_WIN: begin
        ram_we     = 1'b1;
        sum_nxt    = sum_r + {{(SUM_W-32){sample_r[31]}}, sample_r}
                           - {{(SUM_W-32){old_sample[31]}}, old_sample};
        wvalid_nxt[slot_r] = 1'b1;
        slot_nxt   = (slot_r == SLOT_W'(AVG_DEPTH - 1)) ? '0 : slot_r + 1'b1;
        prev_pos_nxt = pos_r;
        state_nxt  = S_EST;
      end

      // Estimate: rounded window average, then branch on mode
      S_EST: begin
        cmd.start    = !launched_r;
        cmd.op       = OP_DIV;
        cmd.a        = ALU_AW'(sum_mag) + ALU_AW'(AVG_DEPTH / 2);
        cmd.b        = ALU_BW'(AVG_DEPTH);
        launched_nxt = 1'b1;
        if (sts.done) begin
          launched_nxt = 1'b0;
          est_nxt      = sat32(sum_r[SUM_W-1], res);
          case (item_r.mode)
            MODE_SPEED: begin
              tgt_nxt   = spd_tgt;
              state_nxt = S_PIMUL;
            end
            MODE_ABS, MODE_REL: begin
              if (item_r.mode == MODE_REL) begin
                base_nxt   = base_eff;
                pdelta_nxt = item_r.target_value;
              end
              left_nxt = left_now;
              if (dist_now < {11'd0, thr_r}) begin
                arr_nxt   = 1'b1;
                state_nxt = S_DONE;
              end else begin
                state_nxt = S_BMUL;
              end
            end
            default: begin
              state_nxt = S_DONE;
            end
          endcase
        end
      end

      // Braking bound: 2 * accel * distance
      S_BMUL: begin
        cmd.start    = !launched_r;
        cmd.op       = OP_MUL;
        cmd.a        = ALU_AW'(dist_r);
        cmd.b        = accel_r;
        launched_nxt = 1'b1;
        if (sts.done) begin
          launched_nxt = 1'b0;
          work_nxt     = res << 1;
          state_nxt    = S_VMUL;
        end
      end

      S_VMUL: begin
        cmd.start    = !launched_r;
        cmd.op       = OP_MUL;
        cmd.a        = ALU_AW'(v_r);
        cmd.b        = v_r;
        launched_nxt = 1'b1;
        if (sts.done) begin
          launched_nxt = 1'b0;
          state_nxt    = (res > work_r) ? S_SQRT : S_RMUL;
        end
      end

      S_SQRT: begin
        cmd.start    = !launched_r;
        cmd.op       = OP_SQRT;
        cmd.a        = work_r;
        launched_nxt = 1'b1;
        if (sts.done) begin
          launched_nxt = 1'b0;
          v_nxt        = v_clamp_sqrt;
          tgt_nxt      = (left_r > 35'sd0) ? {10'd0, v_clamp_sqrt}
                                           : -{10'd0, v_clamp_sqrt};
          state_nxt    = S_PIMUL;
        end
      end

      // Ramp: accel * dt, rounded from microseconds
      S_RMUL: begin
        cmd.start    = !launched_r;
        cmd.op       = OP_MUL;
        cmd.a        = ALU_AW'(accel_r);
        cmd.b        = dt_prof;
        launched_nxt = 1'b1;
        if (sts.done) begin
          launched_nxt = 1'b0;
          work_nxt     = res + ALU_AW'(HALF_US_PER_S);
          state_nxt    = S_RDIV;
        end
      end

      S_RDIV: begin
        cmd.start    = !launched_r;
        cmd.op       = OP_DIV;
        cmd.a        = work_r;
        cmd.b        = US_PER_S;
        launched_nxt = 1'b1;
        if (sts.done) begin
          launched_nxt = 1'b0;
          v_nxt        = v_clamp_ramp;
          tgt_nxt      = (left_r > 35'sd0) ? {10'd0, v_clamp_ramp}
                                           : -{10'd0, v_clamp_ramp};
          state_nxt    = S_PIMUL;
        end
      end

      // Integral step: err * dt / 1e6, rounded
      S_PIMUL: begin
        cmd.start    = !launched_r;
        cmd.op       = OP_MUL;
        cmd.a        = ALU_AW'(err_mag);
        cmd.b        = dt_pi;
        launched_nxt = 1'b1;
        if (sts.done) begin
          launched_nxt = 1'b0;
          work_nxt     = res + ALU_AW'(HALF_US_PER_S);
          state_nxt    = S_PIDIV;
        end
      end

      S_PIDIV: begin
        cmd.start    = !launched_r;
        cmd.op       = OP_DIV;
        cmd.a        = work_r;
        cmd.b        = US_PER_S;
        launched_nxt = 1'b1;
        if (sts.done) begin
          launched_nxt = 1'b0;
          integ_nxt    = integ_sat;
          state_nxt    = S_PPDIV;
        end
      end

      // Proportional term 3*err/5, then drive output
      S_PPDIV: begin
        cmd.start    = !launched_r;
        cmd.op       = OP_DIV;
        cmd.a        = (ALU_AW'(err_mag) << 1) + ALU_AW'(err_mag) + 60'd2;
        cmd.b        = 24'd5;
        launched_nxt = 1'b1;
        if (sts.done) begin
          launched_nxt = 1'b0;
          fwd_nxt      = !pi_sum[42] && (pi_sum != '0);
          duty_nxt     = duty_sum[15:8];
          state_nxt    = S_DONE;
        end
      end

      // Hand the result to the output register once it is free
      S_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt             = 1'b1;
          out_nxt.pwm_duty          = duty_r;
          out_nxt.drive_forward     = fwd_r;
          out_nxt.arrived           = arr_r;
          out_nxt.position_mm_q8    = pos_r;
          out_nxt.speed_estimate_q8 = est_r;
          state_nxt                 = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      launched_r  <= 1'b0;
      prev_pos_r  <= '0;
      sum_r       <= '0;
      slot_r      <= '0;
      wvalid_r    <= '0;
      v_r         <= '0;
      integ_r     <= '0;
      base_r      <= '0;
      pdelta_r    <= '0;
      duty_r      <= '0;
      fwd_r       <= 1'b0;
      arr_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      launched_r  <= launched_nxt;
      prev_pos_r  <= prev_pos_nxt;
      sum_r       <= sum_nxt;
      slot_r      <= slot_nxt;
      wvalid_r    <= wvalid_nxt;
      v_r         <= v_nxt;
      integ_r     <= integ_nxt;
      base_r      <= base_nxt;
      pdelta_r    <= pdelta_nxt;
      duty_r      <= duty_nxt;
      fwd_r       <= fwd_nxt;
      arr_r       <= arr_nxt;
      out_valid_r <= out_valid_nxt;
    end
    item_r   <= item_nxt;
    pos_r    <= pos_nxt;
    sample_r <= sample_nxt;
    est_r    <= est_nxt;
    work_r   <= work_nxt;
    left_r   <= left_nxt;
    tgt_r    <= tgt_nxt;
    out_r    <= out_nxt;
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      spd_lim_r <= SPEED_LIMIT_RST;
      thr_r     <= ARRIVE_THR_RST;
      accel_r   <= ACCEL_RATE_RST;
    end else if (psel && penable && pwrite) begin
      case (paddr[3:2])
        REG_SPEED_LIMIT: spd_lim_r <= pwdata[23:0];
        REG_ARRIVE_THR:  thr_r     <= pwdata[23:0];
        REG_ACCEL_RATE:  accel_r   <= pwdata[23:0];
        default: begin
          spd_lim_r <= spd_lim_r;
        end
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_SPEED_LIMIT: prdata = {8'd0, spd_lim_r};
      REG_ARRIVE_THR:  prdata = {8'd0, thr_r};
      REG_ACCEL_RATE:  prdata = {8'd0, accel_r};
      default:         prdata = '0;
    endcase
  end

  assign pready    = 1'b1;
  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule
